@@ rtl/core/wavhp_pkg.sv @@
// Package for the WAV header parser: payload types, state types and constants.
`timescale 1ns / 1ps
package wavhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] chan_num;
    logic [31:0] rate_hz;
    logic [15:0] bit_depth;
    logic [15:0] frame_bytes;
    logic [1:0]  pcm_kind;
    logic [31:0] frame_total;
    logic [31:0] data_offset;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_FIXED,
    PH_CHUNK,
    PH_SKIP,
    PH_DONE
  } parse_phase_t;

  typedef enum logic {
    CS_RUN,
    CS_DIV
  } ctl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DATA = 2'd1;
  localparam logic [1:0] ST_BAD_FMT = 2'd2;

  localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] TYPE_S16     = 2'd1;
  localparam logic [1:0] TYPE_S24     = 2'd2;

  localparam logic [15:0] WIDTH_16 = 16'd16;
  localparam logic [15:0] WIDTH_24 = 16'd24;

  // Chunk name "data" as read little-endian.
  localparam logic [31:0] NAME_DATA = 32'h6174_6164;

  localparam int POS_CHAN_LO  = 22;
  localparam int POS_CHAN_HI  = 23;
  localparam int POS_RATE_B0  = 24;
  localparam int POS_RATE_B1  = 25;
  localparam int POS_RATE_B2  = 26;
  localparam int POS_RATE_B3  = 27;
  localparam int POS_ALIGN_LO = 32;
  localparam int POS_ALIGN_HI = 33;
  localparam int POS_WIDTH_LO = 34;
  localparam int POS_WIDTH_HI = 35;
  localparam int POS_FMT_END  = 35;

  function automatic logic [1:0] type_of_width(input logic [15:0] w);
    logic [1:0] t;
    t = TYPE_UNKNOWN;
    if (w == WIDTH_16) t = TYPE_S16;
    else if (w == WIDTH_24) t = TYPE_S24;
    return t;
  endfunction

endpackage

@@ rtl/core/wavhp_div.sv @@
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module wavhp_div import wavhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output div_stat_t   stat,
  output logic [31:0] quotient
);

  logic [15:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  always_comb begin
    rem_sh   = {rem_r, quo_r[31]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the carry bit settles the compare.
      if (!rem_sub[16]) begin
        rem_nxt = rem_sub[15:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[15:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ rtl/core/wav_header_chunk_parser.sv @@
// WAV header parser: walks the fmt and chunk headers of a byte stream and reports the data chunk, or its absence.
// A byte is taken each cycle while parsing; a result is registered from the byte that causes it, or,
// when the sample count needs the bit-serial divider, from the divider's quotient once it is done.
// Throughput: one byte per cycle; input stalls while the divider runs and while a result waits.
// Reset: synchronous, active low; returns the parser to the header phase at offset zero.
`timescale 1ns / 1ps
module wav_header_chunk_parser import wavhp_pkg::*; #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;

  parse_phase_t            phase_r, phase_nxt;
  logic [OFFSET_WIDTH-1:0] off_r, off_nxt;
  logic [2:0]              hdr_r, hdr_nxt;
  logic [31:0]             skip_r, skip_nxt;
  logic [63:0]             shift_r, shift_nxt;
  logic [15:0]             chan_r, chan_nxt;
  logic [31:0]             rate_r, rate_nxt;
  logic [15:0]             align_r, align_nxt;
  logic [15:0]             width_r, width_nxt;

  ctl_state_t ctl_r, ctl_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  logic        in_acc;
  logic        res_fire;
  logic        res_div;
  logic [1:0]  res_status;
  logic [31:0] res_offset;
  logic [31:0] res_size;
  logic        div_start;
  div_stat_t   div_stat;
  logic [31:0] div_quo;

  // Working copies: a first byte restarts the parser before the byte is used.
  parse_phase_t            e_phase;
  logic [OFFSET_WIDTH-1:0] pos;
  logic [2:0]              e_hdr;
  logic [31:0]             e_skip;
  logic [63:0]             e_shift;
  logic [15:0]             e_chan;
  logic [31:0]             e_rate;
  logic [15:0]             e_align;
  logic [15:0]             e_width;
  logic [7:0]              b;

  assign in_acc = in_valid && !in_stall;
  assign b      = in_data.data_byte;

  always_comb begin
    if (in_data.first_byte) begin
      e_phase = PH_FIXED;
      pos     = '0;
      e_hdr   = '0;
      e_skip  = '0;
      e_shift = '0;
      e_chan  = '0;
      e_rate  = '0;
      e_align = '0;
      e_width = '0;
    end else begin
      e_phase = phase_r;
      pos     = off_r;
      e_hdr   = hdr_r;
      e_skip  = skip_r;
      e_shift = shift_r;
      e_chan  = chan_r;
      e_rate  = rate_r;
      e_align = align_r;
      e_width = width_r;
    end

    off_nxt    = (pos == OFS_MAX) ? OFS_MAX : pos + OFFSET_WIDTH'(1);
    phase_nxt  = e_phase;
    hdr_nxt    = e_hdr;
    skip_nxt   = e_skip;
    shift_nxt  = e_shift;
    chan_nxt   = e_chan;
    rate_nxt   = e_rate;
    align_nxt  = e_align;
    width_nxt  = e_width;
    res_fire   = 1'b0;
    res_div    = 1'b0;
    res_status = ST_OK;
    res_offset = '0;
    res_size   = shift_nxt[63:32];

    case (e_phase)
      PH_FIXED: begin
        if (pos == OFFSET_WIDTH'(POS_CHAN_LO))  chan_nxt[7:0]   = b;
        if (pos == OFFSET_WIDTH'(POS_CHAN_HI))  chan_nxt[15:8]  = b;
        if (pos == OFFSET_WIDTH'(POS_RATE_B0))  rate_nxt[7:0]   = b;
        if (pos == OFFSET_WIDTH'(POS_RATE_B1))  rate_nxt[15:8]  = b;
        if (pos == OFFSET_WIDTH'(POS_RATE_B2))  rate_nxt[23:16] = b;
        if (pos == OFFSET_WIDTH'(POS_RATE_B3))  rate_nxt[31:24] = b;
        if (pos == OFFSET_WIDTH'(POS_ALIGN_LO)) align_nxt[7:0]  = b;
        if (pos == OFFSET_WIDTH'(POS_ALIGN_HI)) align_nxt[15:8] = b;
        if (pos == OFFSET_WIDTH'(POS_WIDTH_LO)) width_nxt[7:0]  = b;
        if (pos == OFFSET_WIDTH'(POS_WIDTH_HI)) width_nxt[15:8] = b;
        if (pos >= OFFSET_WIDTH'(POS_FMT_END)) begin
          phase_nxt = PH_CHUNK;
          hdr_nxt   = '0;
        end
      end
      PH_SKIP: begin
        if (e_skip != '0) skip_nxt = e_skip - 32'd1;
        if (skip_nxt == '0) begin
          phase_nxt = PH_CHUNK;
          hdr_nxt   = '0;
        end
      end
      PH_CHUNK: begin
        shift_nxt = {b, e_shift[63:8]};
        hdr_nxt   = e_hdr + 3'd1;
        res_size  = shift_nxt[63:32];
        if (hdr_nxt == '0) begin
          if (shift_nxt[31:0] == NAME_DATA) begin
            res_fire   = 1'b1;
            res_div    = (e_align != '0);
            res_offset = 32'(off_nxt);
            if (e_chan == '0 || e_rate == '0 || e_align == '0 || e_width == '0 ||
                type_of_width(e_width) == TYPE_UNKNOWN) begin
              res_status = ST_BAD_FMT;
            end
            phase_nxt = PH_DONE;
          end else if (res_size != '0) begin
            skip_nxt  = res_size;
            phase_nxt = PH_SKIP;
          end
        end
      end
      default: ;
    endcase

    // End of stream without a data header reports what was captured so far.
    if (e_phase != PH_DONE && !res_fire && in_data.last_byte) begin
      res_fire   = 1'b1;
      res_status = ST_NO_DATA;
      res_offset = '0;
      phase_nxt  = PH_DONE;
    end
  end

  // Sequencer: next state.
  always_comb begin
    ctl_nxt = ctl_r;
    unique case (ctl_r)
      CS_RUN: if (in_acc && res_fire && res_div) ctl_nxt = CS_DIV;
      CS_DIV: if (div_stat.done) ctl_nxt = CS_RUN;
      default: ctl_nxt = CS_RUN;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    unique case (ctl_r)
      CS_RUN: begin
        in_stall  = out_valid_r;
        div_start = in_acc && res_fire && res_div;
      end
      CS_DIV: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc && res_fire) begin
      out_nxt.status      = res_status;
      out_nxt.chan_num    = chan_nxt;
      out_nxt.rate_hz     = rate_nxt;
      out_nxt.bit_depth   = width_nxt;
      out_nxt.frame_bytes = align_nxt;
      out_nxt.pcm_kind    = type_of_width(width_nxt);
      out_nxt.frame_total = '0;
      out_nxt.data_offset = res_offset;
      out_valid_nxt       = !res_div;
    end
    if (div_stat.done) begin
      out_nxt.frame_total = div_quo;
      out_valid_nxt       = 1'b1;
    end
  end

  wavhp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (res_size),
    .divisor  (align_nxt),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      phase_r     <= PH_FIXED;
      off_r       <= '0;
      hdr_r       <= '0;
      skip_r      <= '0;
      shift_r     <= '0;
      chan_r      <= '0;
      rate_r      <= '0;
      align_r     <= '0;
      width_r     <= '0;
      ctl_r       <= CS_RUN;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        off_r   <= off_nxt;
        hdr_r   <= hdr_nxt;
        skip_r  <= skip_nxt;
        shift_r <= shift_nxt;
        chan_r  <= chan_nxt;
        rate_r  <= rate_nxt;
        align_r <= align_nxt;
        width_r <= width_nxt;
      end
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_result_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_r && ctl_r == CS_DIV))
    else $error("result shown while the divider is still running");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> ctl_r == CS_DIV)
    else $error("divider finished outside a division");

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == CS_DIV |-> (div_stat.busy || div_stat.done))
    else $error("waiting on a divider that is idle");

  a_ok_has_known_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_OK) |-> out_r.pcm_kind != TYPE_UNKNOWN)
    else $error("status ok reported with an unknown sample type");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall) |=> !out_valid_r)
    else $error("result repeated after its transaction");

endmodule

@@ sim/wav_header_chunk_parser_tb.sv @@
// Self-checking testbench for the WAV header parser: byte streams in, every report checked against a prediction.
`timescale 1ns / 1ps
module wav_header_chunk_parser_tb;
  import wavhp_pkg::*;

  localparam int OFFSET_WIDTH = 32;
  localparam logic [31:0] OFFSET_MAX = 32'((64'd1 << OFFSET_WIDTH) - 64'd1);
  localparam int CYCLE_LIMIT = 600_000;
  localparam int TAIL_CYCLES = 60;
  localparam int ITEM_TARGET = 2000;

  // Chunk tags as they read little-endian from the stream.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_LIST = 32'h5453_494c;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  wav_header_chunk_parser #(.OFFSET_WIDTH(OFFSET_WIDTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Parser state as predicted.
  parse_phase_t p_phase;
  logic [31:0]  p_offset;
  logic [63:0]  p_shift;
  logic [31:0]  p_skip;
  logic [15:0]  p_chan;
  logic [31:0]  p_rate;
  logic [15:0]  p_align;
  logic [15:0]  p_width;
  logic         p_sent;
  logic [2:0]   p_hdr_cnt;

  out_item_t   pending_reports[$];
  logic [7:0]  stream_buf[$];
  bit          idle_enable = 1'b0;
  int          sink_wait = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          bytes_taken = 0;
  int          reports_expected = 0;
  int          reports_checked = 0;
  int          files_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wav_header_chunk_parser regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] offset_next(input logic [31:0] v);
    return (v >= OFFSET_MAX) ? OFFSET_MAX : v + 32'd1;
  endfunction

  function automatic logic [1:0] width_to_type(input logic [15:0] w);
    if (w == 16'd16) return TYPE_S16;
    if (w == 16'd24) return TYPE_S24;
    return TYPE_UNKNOWN;
  endfunction

  function automatic void clear_parser();
    p_phase   = PH_FIXED;
    p_offset  = '0;
    p_shift   = '0;
    p_skip    = '0;
    p_chan    = '0;
    p_rate    = '0;
    p_align   = '0;
    p_width   = '0;
    p_sent    = 1'b0;
    p_hdr_cnt = '0;
  endfunction

  function automatic out_item_t make_report(input logic [1:0] st, input logic [31:0] cnt,
                                            input logic [31:0] ofs);
    out_item_t r;
    r.status      = st;
    r.chan_num    = p_chan;
    r.rate_hz     = p_rate;
    r.bit_depth   = p_width;
    r.frame_bytes = p_align;
    r.pcm_kind    = width_to_type(p_width);
    r.frame_total = cnt;
    r.data_offset = ofs;
    return r;
  endfunction

  // Advances the predicted parser by one accepted byte and queues any report it causes.
  task automatic parse_byte(input in_item_t it);
    logic [31:0] pos;
    logic [31:0] name;
    logic [31:0] size;
    logic [31:0] cnt;
    logic [1:0]  st;
    if (it.first_byte) clear_parser();
    pos = p_offset;
    p_offset = offset_next(pos);
    bytes_taken++;
    if (p_phase == PH_DONE || p_sent) return;
    case (p_phase)
      PH_FIXED: begin
        case (pos)
          POS_CHAN_LO:  p_chan[7:0]    = it.data_byte;
          POS_CHAN_HI:  p_chan[15:8]   = it.data_byte;
          POS_RATE_B0:  p_rate[7:0]    = it.data_byte;
          POS_RATE_B1:  p_rate[15:8]   = it.data_byte;
          POS_RATE_B2:  p_rate[23:16]  = it.data_byte;
          POS_RATE_B3:  p_rate[31:24]  = it.data_byte;
          POS_ALIGN_LO: p_align[7:0]   = it.data_byte;
          POS_ALIGN_HI: p_align[15:8]  = it.data_byte;
          POS_WIDTH_LO: p_width[7:0]   = it.data_byte;
          POS_WIDTH_HI: p_width[15:8]  = it.data_byte;
          default: ;
        endcase
        if (pos >= POS_FMT_END) begin
          p_phase = PH_CHUNK;
          p_hdr_cnt = '0;
        end
      end
      PH_SKIP: begin
        if (p_skip != 0) p_skip = p_skip - 32'd1;
        if (p_skip == 0) begin
          p_phase = PH_CHUNK;
          p_hdr_cnt = '0;
        end
      end
      default: begin
        p_shift = {it.data_byte, p_shift[63:8]};
        p_hdr_cnt = p_hdr_cnt + 3'd1;
        if (p_hdr_cnt == 3'd0) begin
          name = p_shift[31:0];
          size = p_shift[63:32];
          if (name == NAME_DATA) begin
            cnt = (p_align != 0) ? size / {16'd0, p_align} : 32'd0;
            st = ST_OK;
            if (p_chan == 0 || p_rate == 0 || p_align == 0 || p_width == 0 ||
                width_to_type(p_width) == TYPE_UNKNOWN) st = ST_BAD_FMT;
            pending_reports.push_back(make_report(st, cnt, offset_next(pos)));
            reports_expected++;
            p_sent = 1'b1;
            p_phase = PH_DONE;
            return;
          end
          if (size != 0) begin
            p_skip = size;
            p_phase = PH_SKIP;
          end
        end
      end
    endcase
    if (it.last_byte) begin
      pending_reports.push_back(make_report(ST_NO_DATA, 32'd0, 32'd0));
      reports_expected++;
      p_sent = 1'b1;
      p_phase = PH_DONE;
    end
  endtask

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_report(input out_item_t got);
    out_item_t want;
    reports_checked++;
    if (pending_reports.size() == 0) begin
      $error("report with none pending: status %0d, data_offset 0x%0h",
             got.status, got.data_offset);
      fail_count++;
      return;
    end
    want = pending_reports.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("chan_num", 32'(want.chan_num), 32'(got.chan_num));
    compare_field("rate_hz", want.rate_hz, got.rate_hz);
    compare_field("bit_depth", 32'(want.bit_depth), 32'(got.bit_depth));
    compare_field("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
    compare_field("pcm_kind", 32'(want.pcm_kind), 32'(got.pcm_kind));
    compare_field("frame_total", want.frame_total, got.frame_total);
    compare_field("data_offset", want.data_offset, got.data_offset);
  endtask

  // Both handshakes are observed here on values from before the edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (in_valid && !in_stall) parse_byte(in_data);
      if (out_valid && !out_stall) check_report(out_data);
    end
  end

  // The receiver holds each result off for a freshly drawn number of cycles.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      sink_wait = idle_enable ? $urandom_range(0, 10) : 0;
      out_stall <= (sink_wait != 0);
    end else if (out_valid && out_stall) begin
      if (sink_wait > 0) sink_wait = sink_wait - 1;
      out_stall <= (sink_wait != 0);
    end
  end

  task automatic send_byte(input in_item_t it);
    int gap;
    gap = idle_enable ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  function automatic void put8(input logic [7:0] b);
    stream_buf.push_back(b);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  // RIFF header and a 24-byte fmt chunk; the RIFF size, format tag and byte rate, which the parser ignores, are random.
  function automatic void put_header(input logic [15:0] chan, input logic [31:0] rate,
                                     input logic [15:0] align, input logic [15:0] bits);
    stream_buf.delete();
    put32(TAG_RIFF);
    put32($urandom);
    put32(TAG_WAVE);
    put32(TAG_FMT);
    put32(32'd16);
    put16(16'($urandom_range(0, 3)));
    put16(chan);
    put32(rate);
    put32($urandom);
    put16(align);
    put16(bits);
  endfunction

  function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] size,
                                    input int payload);
    put32(tag);
    put32(size);
    repeat (payload) put8(8'($urandom));
  endfunction

  function automatic void cut_file(input int n);
    while (stream_buf.size() > n) void'(stream_buf.pop_back());
  endfunction

  task automatic send_file(input bit mark_first, input bit mark_last);
    in_item_t it;
    for (int i = 0; i < stream_buf.size(); i++) begin
      it.data_byte  = stream_buf[i];
      it.first_byte = mark_first && (i == 0);
      it.last_byte  = mark_last && (i == stream_buf.size() - 1);
      send_byte(it);
    end
    files_sent++;
  endtask

  // A plausible file with random content; the fmt fields are sometimes zero or odd.
  function automatic void build_random_file();
    logic [15:0] chan;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] rate;
    logic [31:0] size;
    int          r;
    r = $urandom_range(0, 9);
    chan = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(1, 2));
    r = $urandom_range(0, 99);
    if (r < 70) bits = $urandom_range(0, 1) ? 16'd16 : 16'd24;
    else if (r < 85) bits = 16'($urandom);
    else if (r < 93) bits = 16'd0;
    else bits = $urandom_range(0, 1) ? 16'd8 : 16'd32;
    r = $urandom_range(0, 99);
    if (r < 5) rate = 32'd0;
    else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: rate = 32'd8000;
        1: rate = 32'd44100;
        2: rate = 32'd48000;
        default: rate = 32'd96000;
      endcase
    end else rate = $urandom;
    r = $urandom_range(0, 9);
    if (r < 8) align = 16'((32'(chan) * 32'(bits)) / 8);
    else if (r == 8) align = 16'd0;
    else align = 16'($urandom);
    put_header(chan, rate, align, bits);
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 99);
      if (r < 80) size = $urandom_range(0, 12);
      else if (r < 95) size = $urandom_range(13, 64);
      else size = $urandom_range(65, 250);
      put_chunk($urandom, size, size);
    end
    size = $urandom_range(0, 1) ? 32'(align) * $urandom_range(0, 50) : 32'($urandom);
    put_chunk(NAME_DATA, size, $urandom_range(0, 6));
  endfunction

  task automatic test_directed_files();
    // Counting from reset with no first_byte marker.
    idle_enable = 1'b0;
    put_header(16'd2, 32'd44100, 16'd4, 16'd16);
    put_chunk(NAME_DATA, 32'd400, 4);
    send_file(1'b0, 1'b1);
    idle_enable = 1'b1;
    put_header(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd24);
    put_chunk(NAME_DATA, 32'hFFFF_FFFF, 2);
    send_file(1'b1, 1'b1);
    // An odd-sized chunk without padding and an empty chunk before the data.
    put_header(16'd1, 32'd8000, 16'd2, 16'd16);
    put_chunk(TAG_LIST, 32'd5, 5);
    put_chunk(TAG_FACT, 32'd0, 0);
    put_chunk(NAME_DATA, 32'd7, 3);
    send_file(1'b1, 1'b1);
    // Bad formats: zero channels, unknown width, zero block align, zero rate and width.
    put_header(16'd0, 32'd48000, 16'd4, 16'd16);
    put_chunk(NAME_DATA, 32'd64, 0);
    send_file(1'b1, 1'b1);
    put_header(16'd2, 32'd48000, 16'd6, 16'd8);
    put_chunk(NAME_DATA, 32'd60, 1);
    send_file(1'b1, 1'b1);
    idle_enable = 1'b0;
    put_header(16'd2, 32'd96000, 16'd0, 16'd24);
    put_chunk(NAME_DATA, 32'd600, 1);
    send_file(1'b1, 1'b1);
    put_header(16'd1, 32'd0, 16'd2, 16'd0);
    put_chunk(NAME_DATA, 32'd0, 0);
    send_file(1'b1, 1'b1);
    // Streams that end before a data header: inside fmt, inside a header, inside a skip.
    idle_enable = 1'b1;
    put_header(16'd2, 32'd44100, 16'd4, 16'd16);
    cut_file(26);
    send_file(1'b1, 1'b1);
    put_header(16'd2, 32'd44100, 16'd4, 16'd16);
    put_chunk(NAME_DATA, 32'd100, 0);
    cut_file(40);
    send_file(1'b1, 1'b1);
    put_header(16'd2, 32'd22050, 16'd4, 16'd16);
    put_chunk(TAG_LIST, 32'hFFFF_FFF0, 10);
    send_file(1'b1, 1'b1);
    stream_buf.delete();
    put8(8'hFF);
    send_file(1'b1, 1'b1);
    // The data header completes on the final byte.
    put_header(16'd2, 32'd44100, 16'd4, 16'd16);
    put_chunk(NAME_DATA, 32'd1000, 0);
    send_file(1'b1, 1'b1);
    // A file cut short with no end marker, restarted by the next one.
    put_header(16'd6, 32'd48000, 16'd18, 16'd24);
    cut_file(30);
    send_file(1'b1, 1'b0);
    put_header(16'd6, 32'd48000, 16'd18, 16'd24);
    put_chunk(NAME_DATA, 32'd1800, 3);
    send_file(1'b1, 1'b1);
  endtask

  // The sender stops before each of these files until every report has come.
  task automatic test_drain_pause();
    repeat (3) begin
      wait_drained();
      idle_enable = ($urandom_range(0, 1) != 0);
      build_random_file();
      send_file(1'b1, 1'b1);
    end
  endtask

  task automatic test_random_files();
    in_item_t it;
    int       kind;
    while (bytes_taken < ITEM_TARGET) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        build_random_file();
        send_file($urandom_range(0, 19) != 0, $urandom_range(0, 4) != 0);
      end else if (kind < 90) begin
        build_random_file();
        cut_file($urandom_range(1, stream_buf.size()));
        send_file(1'b1, $urandom_range(0, 6) != 0);
      end else begin
        repeat ($urandom_range(1, 40)) begin
          it.data_byte  = 8'($urandom);
          it.first_byte = ($urandom_range(0, 15) == 0);
          it.last_byte  = ($urandom_range(0, 15) == 0);
          send_byte(it);
        end
        files_sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_files();
    test_drain_pause();
    test_random_files();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end
    $display("Covered %0d streams, %0d bytes accepted and %0d reports compared.",
             files_sent, bytes_taken, reports_checked);
    if (fail_count == 0) begin
      $display("wav_header_chunk_parser regression: pass");
    end else begin
      $display("wav_header_chunk_parser regression: fail");
    end
    $finish;
  end

endmodule

@@ wav_header_chunk_parser.f @@
rtl/core/wavhp_pkg.sv
rtl/core/wavhp_div.sv
rtl/core/wav_header_chunk_parser.sv
sim/wav_header_chunk_parser_tb.sv
